// ===== rtl/core/csma_pkg.sv =====
// ============================================================================
// csma_pkg: shared types and codes for the CSMA/CA backoff retry controller
// Transaction payloads, configuration and state records, event/result codes.
// ============================================================================
package csma_pkg;

    // event codes
    localparam logic [1:0] CMD_ATTEMPT = 2'd0;
    localparam logic [1:0] CMD_SLOT    = 2'd1;
    localparam logic [1:0] CMD_ACK     = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT = 2'd3;

    // access modes
    localparam logic [1:0] MODE_NONE       = 2'd0;
    localparam logic [1:0] MODE_CONTENTION = 2'd1;
    localparam logic [1:0] MODE_SCHEDULED  = 2'd2;

    // outcome codes
    localparam logic [2:0] OUT_NONE        = 3'd0;
    localparam logic [2:0] OUT_ACKED_FIRST = 3'd1;
    localparam logic [2:0] OUT_ACKED_RETRY = 3'd2;
    localparam logic [2:0] OUT_FAIL_NOACK  = 3'd3;
    localparam logic [2:0] OUT_FAIL_BUSY   = 3'd4;
    localparam logic [2:0] OUT_DROPPED     = 3'd5;

    // action codes
    localparam logic [2:0] ACT_IDLE        = 3'd0;
    localparam logic [2:0] ACT_SENSE_ONE   = 3'd1;
    localparam logic [2:0] ACT_SENSE_THREE = 3'd2;
    localparam logic [2:0] ACT_SEND_ACK    = 3'd3;
    localparam logic [2:0] ACT_SEND_NOACK  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_CW_MIN      = 2'd0;
    localparam logic [1:0] REG_CW_MAX      = 2'd1;
    localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

    localparam logic [8:0] CW_MIN_RESET      = 9'd16;
    localparam logic [8:0] CW_MAX_RESET      = 9'd64;
    localparam logic [3:0] MAX_RETRIES_RESET = 4'd3;
    localparam logic [8:0] CW_LIMIT          = 9'd256;
    localparam logic [3:0] CNT_MAX           = 4'd15;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  access_mode;
        logic        channel_clear;
        logic        fits_in_period;
        logic        packet_available;
        logic        queued_needs_ack;
        logic [15:0] random_value;
    } evt_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic [2:0] action;
        logic       take_packet;
        logic [8:0] backoff_left;
        logic [8:0] window_now;
    } res_t;

    typedef struct packed {
        logic [8:0] cw_min;
        logic [8:0] cw_max;
        logic [3:0] max_retries;
    } cfg_t;

    typedef struct packed {
        logic       holding;
        logic       held_ack;
        logic [3:0] send_cnt;
        logic [3:0] busy_cnt;
        logic [8:0] cw;
        logic       dphase;
        logic [8:0] backoff;
        logic       awaiting;
        logic       sensing;
    } state_t;

endpackage

// ===== rtl/core/csma_cfg_regs.sv =====
// ============================================================================
// csma_cfg_regs: configuration register file
// Decodes plain register writes into the window and retry limits.
// ============================================================================
module csma_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data,
    output csma_pkg::cfg_t    cfg
);

    csma_pkg::cfg_t cfg_reg;
    csma_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                csma_pkg::REG_CW_MIN:      cfg_next.cw_min      = cfg_data;
                csma_pkg::REG_CW_MAX:      cfg_next.cw_max      = cfg_data;
                csma_pkg::REG_MAX_RETRIES: cfg_next.max_retries = cfg_data[3:0];
                default:                   cfg_next = cfg_reg; // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cw_min      <= csma_pkg::CW_MIN_RESET;
            cfg_reg.cw_max      <= csma_pkg::CW_MAX_RESET;
            cfg_reg.max_retries <= csma_pkg::MAX_RETRIES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/csma_step.sv =====
// ============================================================================
// csma_step: single-event state update
// Combinational next state and result for one event against the held state.
// ============================================================================
module csma_step (
    input  csma_pkg::state_t cur,
    input  csma_pkg::cfg_t   cfg,
    input  csma_pkg::evt_t   evt,
    output csma_pkg::state_t nxt,
    output csma_pkg::res_t   res
);

    typedef struct packed {
        csma_pkg::state_t s;
        logic [2:0]       outcome;
        logic [2:0]       action;
        logic             take;
    } work_t;

    function automatic logic [8:0] draw(input logic [8:0] cw, input logic [15:0] rnd);
        logic [8:0] m;
        logic [9:0] sum;
        m   = (cw == 9'd0) ? 9'd0 : (cw - 9'd1);
        sum = 10'd1 + {1'b0, rnd[8:0] & m};
        return sum[8:0];   // at most 511, so the low nine bits never wrap
    endfunction

    function automatic work_t release_pkt(input work_t w);
        work_t r;
        r = w;
        r.s.holding  = 1'b0;
        r.s.send_cnt = 4'd0;
        r.s.busy_cnt = 4'd0;
        return r;
    endfunction

    function automatic work_t send_now(input work_t w);
        work_t r;
        r = w;
        r.s.sensing = 1'b0;
        if (r.s.held_ack)
        begin
            r.s.awaiting = 1'b1;
            if (r.s.send_cnt != csma_pkg::CNT_MAX)
                r.s.send_cnt = r.s.send_cnt + 4'd1;
            r.action = csma_pkg::ACT_SEND_ACK;
        end
        else
        begin
            r        = release_pkt(r);
            r.action = csma_pkg::ACT_SEND_NOACK;
        end
        return r;
    endfunction

    function automatic work_t start_tx(input work_t w, input csma_pkg::evt_t e);
        work_t r;
        r = w;
        if (e.access_mode == csma_pkg::MODE_CONTENTION)
        begin
            if (r.s.backoff == 9'd0)
                r.s.backoff = draw(r.s.cw, e.random_value);
            r.s.sensing = 1'b1;
            r.action    = csma_pkg::ACT_SENSE_ONE;
        end
        else if (e.fits_in_period)
        begin
            r = send_now(r);
        end
        return r;
    endfunction

    function automatic work_t attempt(input work_t w, input csma_pkg::evt_t e,
                                      input csma_pkg::cfg_t c);
        work_t      r;
        logic [4:0] tries;
        r     = w;
        tries = {1'b0, r.s.send_cnt} + {1'b0, r.s.busy_cnt};
        if ((e.access_mode == csma_pkg::MODE_CONTENTION ||
             e.access_mode == csma_pkg::MODE_SCHEDULED) &&
            !r.s.awaiting && !r.s.sensing)
        begin
            if (r.s.holding && tries < {1'b0, c.max_retries})
            begin
                r = start_tx(r, e);
            end
            else
            begin
                if (r.s.holding)
                begin
                    r.outcome = (r.s.busy_cnt == c.max_retries) ?
                                csma_pkg::OUT_FAIL_BUSY : csma_pkg::OUT_DROPPED;
                    r = release_pkt(r);
                end
                if (e.packet_available)
                begin
                    r.s.holding  = 1'b1;
                    r.s.held_ack = e.queued_needs_ack;
                    r.s.send_cnt = 4'd0;
                    r.s.busy_cnt = 4'd0;
                    r.take       = 1'b1;
                    r = start_tx(r, e);
                end
            end
        end
        return r;
    endfunction

    work_t      w;
    logic       do_att;
    logic [4:0] tries;
    logic [9:0] dbl;

    always_comb
    begin
        w.s       = cur;
        w.outcome = csma_pkg::OUT_NONE;
        w.action  = csma_pkg::ACT_IDLE;
        w.take    = 1'b0;
        do_att    = 1'b0;
        tries     = {1'b0, cur.send_cnt} + {1'b0, cur.busy_cnt};
        dbl       = {cur.cw, 1'b0};

        case (evt.cmd)
            csma_pkg::CMD_ATTEMPT:
            begin
                do_att = 1'b1;
            end
            csma_pkg::CMD_SLOT:
            begin
                if (cur.sensing)
                begin
                    if (!cur.holding)
                    begin
                        w.s.sensing = 1'b0;
                    end
                    else if (!evt.fits_in_period)
                    begin
                        w.s.sensing = 1'b0;
                        if (cur.busy_cnt != csma_pkg::CNT_MAX)
                            w.s.busy_cnt = cur.busy_cnt + 4'd1;
                    end
                    else if (evt.channel_clear)
                    begin
                        if (cur.backoff != 9'd0)
                            w.s.backoff = cur.backoff - 9'd1;
                        if (w.s.backoff != 9'd0)
                            w.action = csma_pkg::ACT_SENSE_ONE;
                        else
                            w = send_now(w);
                    end
                    else
                    begin
                        w.action = csma_pkg::ACT_SENSE_THREE;
                    end
                end
            end
            csma_pkg::CMD_ACK:
            begin
                w.s.awaiting = 1'b0;
                if (cur.holding && cur.send_cnt != 4'd0)
                begin
                    w.outcome   = (cur.send_cnt == 4'd1) ?
                                  csma_pkg::OUT_ACKED_FIRST : csma_pkg::OUT_ACKED_RETRY;
                    w           = release_pkt(w);
                    w.s.sensing = 1'b0;
                    w.s.cw      = cfg.cw_min;
                    do_att      = 1'b1;
                end
            end
            csma_pkg::CMD_TIMEOUT:
            begin
                if (cur.awaiting)
                begin
                    w.s.awaiting = 1'b0;
                    w.s.dphase   = !cur.dphase;
                    if (!cur.dphase && cur.cw < cfg.cw_max && cur.cw < csma_pkg::CW_LIMIT)
                        w.s.cw = (dbl > {1'b0, csma_pkg::CW_LIMIT}) ?
                                 csma_pkg::CW_LIMIT : dbl[8:0];
                    if (tries == {1'b0, cfg.max_retries})
                    begin
                        w.outcome = csma_pkg::OUT_FAIL_NOACK;
                        w         = release_pkt(w);
                    end
                    do_att = 1'b1;
                end
            end
            default:
            begin
                do_att = 1'b0;
            end
        endcase

        if (do_att)
            w = attempt(w, evt, cfg);
    end

    assign nxt              = w.s;
    assign res.outcome      = w.outcome;
    assign res.action       = w.action;
    assign res.take_packet  = w.take;
    assign res.backoff_left = w.s.backoff;
    assign res.window_now   = w.s.cw;

endmodule

// ===== rtl/core/csma_backoff_retry_controller_unit.sv =====
// ============================================================================
// csma_backoff_retry_controller_unit: CSMA/CA transmit backoff and retry control
// Event-driven channel access for one held packet with window doubling.
// ============================================================================
// Usage:
//   Event channel (evt_valid / evt_stall / evt): one transaction per MAC
//   event - attempt request, carrier-sense slot result, ACK or ACK timeout.
//   Result channel (res_valid / res_stall / res): exactly one transaction
//   per event, in order, carrying outcome, action, take_packet, the backoff
//   slots left and the current contention window.
//   Config port (cfg_we / cfg_index / cfg_data): 0 cw_min, 1 cw_max,
//   2 max_retries; write only while no event is in flight.
// Pipeline and throughput:
//   The event is registered in the event register, then passes through the
//   single-pass state update into the result register. One event per cycle
//   sustained while res_stall is low; the state update logic is the only loop.
// Reset:
//   rst_n clears both stages, drops any held packet and loads the window
//   with 16, cw_min 16, cw_max 64, max_retries 3.
// Stall:
//   While res_stall holds a pending result, one more event is accepted into
//   the event register; then evt_stall rises until the result is taken.
// ============================================================================
module csma_backoff_retry_controller_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_stall,
    input  csma_pkg::evt_t    evt,
    output logic              res_valid,
    input  logic              res_stall,
    output csma_pkg::res_t    res,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data
);

    csma_pkg::cfg_t   cfg;
    csma_pkg::state_t state_reg;
    csma_pkg::state_t state_next;
    csma_pkg::evt_t   evt_data_reg;
    csma_pkg::res_t   res_data_reg;
    csma_pkg::res_t   res_data_next;
    logic             evt_valid_reg;
    logic             evt_valid_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             advance;
    logic             evt_take;

    csma_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csma_step u_step (
        .cur (state_reg),
        .cfg (cfg),
        .evt (evt_data_reg),
        .nxt (state_next),
        .res (res_data_next)
    );

    // The event stage moves into the result stage whenever the result
    // register is empty or being drained this cycle.
    assign advance        = evt_valid_reg && (!res_valid_reg || !res_stall);
    assign evt_stall      = evt_valid_reg && !advance;
    assign evt_take       = evt_valid && !evt_stall;
    assign evt_valid_next = evt_take || (evt_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            // all state cleared, window at the reset cw_min
            state_reg     <= {1'b0, 1'b0, 4'd0, 4'd0, csma_pkg::CW_MIN_RESET,
                              1'b0, 9'd0, 1'b0, 1'b0};
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt_take)
            evt_data_reg <= evt;
        if (advance)
            res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

endmodule

// ===== rtl/core/csma_checker.sv =====
// ============================================================================
// csma_checker: port-level checks for the backoff retry controller
// Result hold under stall, code ranges and the event behind each fresh result.
// ============================================================================
module csma_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              evt_valid,
    input logic              evt_stall,
    input logic              res_valid,
    input logic              res_stall,
    input csma_pkg::res_t    res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.outcome <= csma_pkg::OUT_DROPPED) &&
                      (res.action <= csma_pkg::ACT_SEND_NOACK))
        else $error("result code out of range");

    // a fresh result always comes from an event taken through the event register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(evt_valid && !evt_stall, 2))
        else $error("result without matching event");

endmodule

bind csma_backoff_retry_controller_unit csma_checker u_csma_checker (.*);
